// File: rtl/l3bs_pkg.sv
// ----------------------------------------------------------------------------
// l3bs_pkg
// Shared types and constants for the L3 bus byte serialiser.
// ----------------------------------------------------------------------------
package l3bs_pkg;

    localparam int BITS_PER_TRANSFER = 8;
    localparam int BIT_CNT_W         = $clog2(BITS_PER_TRANSFER);

    localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST = BIT_CNT_W'(BITS_PER_TRANSFER - 1);

    // Transfer kinds carried in op
    localparam logic OP_ADDRESS = 1'b0;
    localparam logic OP_DATA    = 1'b1;

    // Pin-state sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HALT,
        ST_START,
        ST_BIT_LO,
        ST_BIT_HI,
        ST_STOP
    } seq_state_t;

    // One pin state as it leaves the sequencer
    typedef struct packed {
        logic pin_mode;
        logic pin_clock;
        logic pin_data;
        logic last_state;
    } pin_state_t;

endpackage

// File: rtl/l3_bus_byte_serializer_unit.sv
// ----------------------------------------------------------------------------
// l3_bus_byte_serializer_unit
// L3 bus master transmitter: turns one byte request into the sequence of
// mode/clock/data pin states that sends it, one pin state per transaction.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  ------------------------------------------
//  input    in_valid / in_stall  op, byte_value, halt_first
//  output   out_valid/ out_stall pin_mode, pin_clock, pin_data, last_state
//
//  An address byte gives 18 pin states, a data byte 18 or 19 (halt state).
//  One pin state leaves per cycle while the output is not stalled. A byte
//  is accepted only in idle, so the next one waits until the stop state
//  has gone out; the sequencer walks the byte one bit a step.
//  in_stall is high whenever the sequencer is busy; a stall on the output
//  holds the sequencer in place and the output register keeps its state.
//  Reset clears the sequencer and the output valid flag; no clearing pass.
//
module l3_bus_byte_serializer_unit
    import l3bs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [7:0] byte_value,
    input  logic       halt_first,

    output logic out_valid,
    input  logic out_stall,
    output logic pin_mode,
    output logic pin_clock,
    output logic pin_data,
    output logic last_state
);

    // Sequencer state
    seq_state_t           state_reg, state_next;
    logic [7:0]           shift_reg, shift_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                 kind_reg, kind_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    pin_state_t out_reg, out_next;

    // Current pin state and handshake terms
    pin_state_t cur_pins;
    logic       in_accept;
    logic       advance;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    // Advance whenever there is a pin state to emit and room in the output stage
    assign advance = (state_reg != ST_IDLE) && (!out_valid_reg || !out_stall);

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (op == OP_DATA && halt_first)
                        state_next = ST_HALT;
                    else
                        state_next = ST_START;
                end
            end
            ST_HALT:
            begin
                if (advance)
                    state_next = ST_START;
            end
            ST_START:
            begin
                if (advance)
                    state_next = ST_BIT_LO;
            end
            ST_BIT_LO:
            begin
                if (advance)
                    state_next = ST_BIT_HI;
            end
            ST_BIT_HI:
            begin
                if (advance)
                    state_next = (bit_cnt_reg == BIT_CNT_LAST) ? ST_STOP : ST_BIT_LO;
            end
            ST_STOP:
            begin
                if (advance)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic: pin levels for the current state, datapath updates
    always_comb
    begin
        cur_pins     = '0;
        shift_next   = shift_reg;
        bit_cnt_next = bit_cnt_reg;
        kind_next    = kind_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Latch the request; the first pin state goes out from the halt or start state that follows
                if (in_accept)
                begin
                    shift_next   = byte_value;
                    kind_next    = op;
                    bit_cnt_next = '0;
                end
            end
            ST_HALT:
            begin
                cur_pins = '{pin_mode: 1'b0, pin_clock: 1'b1, pin_data: 1'b0, last_state: 1'b0};
            end
            ST_START:
            begin
                cur_pins = '{pin_mode: kind_reg, pin_clock: 1'b1, pin_data: 1'b0,
                             last_state: 1'b0};
            end
            ST_BIT_LO:
            begin
                cur_pins = '{pin_mode: kind_reg, pin_clock: 1'b0, pin_data: shift_reg[0],
                             last_state: 1'b0};
            end
            ST_BIT_HI:
            begin
                cur_pins = '{pin_mode: kind_reg, pin_clock: 1'b1, pin_data: shift_reg[0],
                             last_state: 1'b0};
                // Drop the sent bit once the high phase has gone out
                if (advance)
                begin
                    shift_next   = {1'b0, shift_reg[7:1]};
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                end
            end
            ST_STOP:
            begin
                cur_pins = '{pin_mode: 1'b1, pin_clock: 1'b1, pin_data: 1'b0, last_state: 1'b1};
            end
            default:
            begin
                cur_pins = '0;
            end
        endcase
    end

    // Output stage: load on advance, clear when taken with nothing behind it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        priority if (advance)
        begin
            out_valid_next = 1'b1;
            out_next       = cur_pins;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            kind_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        out_reg   <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign pin_mode   = out_reg.pin_mode;
    assign pin_clock  = out_reg.pin_clock;
    assign pin_data   = out_reg.pin_data;
    assign last_state = out_reg.last_state;

endmodule
